>>> rtl/l3d_pkg.sv
// ----------------------------------------------------------------------------
// l3d_pkg
// Shared constants, request and register codes, and the control struct that
// runs the row accumulator of the 3D life-like cellular automaton.
// ----------------------------------------------------------------------------
package l3d_pkg;

    localparam int MAX_DIM_DEF = 32;

    localparam int CNT_W     = 5;
    localparam int REQ_W     = 2;
    localparam int POS_W     = 5;
    localparam int SIZE_W    = 6;
    localparam int GEN_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 6;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ADV   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NOP   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOORE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OVER   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BIRTH  = 3'd6;

    localparam logic [SIZE_W-1:0] SIZE_RST  = 6'd32;
    localparam logic [CNT_W-1:0]  UNDER_RST = 5'd2;
    localparam logic [CNT_W-1:0]  OVER_RST  = 5'd3;
    localparam logic [CNT_W-1:0]  BIRTH_RST = 5'd3;

    // Class of a neighbour row by how many of its y and z offsets are nonzero.
    localparam logic [1:0] CLS_SELF = 2'd0;
    localparam logic [1:0] CLS_FACE = 2'd1;
    localparam logic [1:0] CLS_EDGE = 2'd2;

    typedef struct packed {
        logic       clear;
        logic       add;
        logic       rowok;
        logic       center;
        logic [1:0] cls;
    } t_acc_ctl;

endpackage

>>> rtl/life_3d_cellular_automaton.sv
// ----------------------------------------------------------------------------
// life_3d_cellular_automaton
// 3D life-like cellular automaton held in two row-wide RAM banks.
// ----------------------------------------------------------------------------
// Out-of-range and unused (type-3) items are answered from idle; a write
// reads and rewrites its row; a read makes nine row reads through the single RAM read port.
// An advance gathers and rewrites each x-row over all 2^(2*clog2(MAX_DIM))
// rows. One item at a time; results cannot be stalled. After reset a
// clearing pass of one row per cycle runs with busy high.
module life_3d_cellular_automaton
    import l3d_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [POS_W-1:0]     i_pos_x,
    input  logic [POS_W-1:0]     i_pos_y,
    input  logic [POS_W-1:0]     i_pos_z,
    input  logic                 i_alive_in,
    output logic                 o_result_valid,
    output logic                 o_alive_out,
    output logic [CNT_W-1:0]     o_neighbour_count,
    output logic [GEN_W-1:0]     o_generation,
    output logic                 o_out_of_range,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int XW   = $clog2(MAX_DIM);
    localparam int AW   = 2 * XW;
    localparam int ROWS = 1 << AW;
    localparam int EW   = ($clog2(MAX_DIM + 1) > SIZE_W) ? $clog2(MAX_DIM + 1) : SIZE_W;
    localparam int CW   = (EW > XW + 1) ? EW : XW + 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_WREAD, S_WMOD, S_GATHER, S_DRAIN, S_FINISH
    } t_state;

    t_state             r_state;
    logic [REQ_W-1:0]   r_req;
    logic [AW-1:0]      r_row;
    logic [XW-1:0]      r_px;
    logic               r_alive_in;
    logic [1:0]         r_dy, r_dz;
    logic               r_bank;
    logic [GEN_W-1:0]   r_gen;
    t_acc_ctl           r_dctl;
    logic               r_strobe, r_alive, r_oor;
    logic [CNT_W-1:0]   r_ncnt;
    logic [SIZE_W-1:0]  r_size_x, r_size_y, r_size_z;
    logic               r_moore;
    logic [CNT_W-1:0]   r_under, r_over, r_birth;

    logic [EW-1:0]      eff_x, eff_y, eff_z;
    logic [MAX_DIM-1:0] xmask;
    logic [XW-1:0]      cy, cz, ny, nz;
    logic [CW-1:0]      ty, tz;
    logic               rowok, pos_oor, accept;
    logic [AW-1:0]      raddr;
    logic [MAX_DIM-1:0] rd0, rd1, rdata, wdata, new_row;
    logic               we0, we1, we;
    logic               wbank;
    logic               sel_alive;
    logic [CNT_W-1:0]   sel_cnt;
    t_acc_ctl           ctl;

    function automatic logic [EW-1:0] eff_size(input logic [SIZE_W-1:0] s);
        return (EW'(s) > EW'(MAX_DIM)) ? EW'(MAX_DIM) : EW'(s);
    endfunction

    assign eff_x = eff_size(r_size_x);
    assign eff_y = eff_size(r_size_y);
    assign eff_z = eff_size(r_size_z);

    always_comb begin
        for (int i = 0; i < MAX_DIM; i++) begin
            xmask[i] = (CW'(i) < CW'(eff_x));
        end
    end

    assign cy = r_row[XW-1:0];
    assign cz = r_row[AW-1:XW];

    // Neighbour row coordinate is center + offset - 1; zero in ty means y = -1.
    assign ty = CW'(cy) + CW'(r_dy);
    assign tz = CW'(cz) + CW'(r_dz);
    assign ny = XW'(ty - CW'(1));
    assign nz = XW'(tz - CW'(1));
    assign rowok = (ty != '0) && ((ty - CW'(1)) < CW'(eff_y))
                && (tz != '0) && ((tz - CW'(1)) < CW'(eff_z));

    assign pos_oor = !((CW'(i_pos_x) < CW'(eff_x)) && (CW'(i_pos_y) < CW'(eff_y))
                    && (CW'(i_pos_z) < CW'(eff_z)));

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign raddr  = (r_state == S_WREAD) ? r_row : {nz, ny};
    assign rdata  = r_bank ? rd1 : rd0;

    always_comb begin
        we    = 1'b0;
        wbank = r_bank;
        wdata = new_row;
        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                wbank = 1'b0;
                wdata = '0;
            end
            S_WMOD: begin
                we    = 1'b1;
                wdata = rdata;
                wdata[r_px] = r_alive_in;
            end
            S_FINISH: begin
                we    = (r_req == REQ_ADV);
                wbank = !r_bank;
            end
            default: ;
        endcase
        we0 = we && !wbank;
        we1 = we && wbank;
    end

    always_comb begin
        ctl        = r_dctl;
        ctl.clear  = (r_state == S_GATHER) && (r_dy == 2'd0) && (r_dz == 2'd0);
    end

    l3d_ram #(.WIDTH(MAX_DIM), .DEPTH(ROWS)) u_bank0 (
        .i_clk  (i_clk),
        .i_we   (we0),
        .i_waddr(r_row),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rd0)
    );

    l3d_ram #(.WIDTH(MAX_DIM), .DEPTH(ROWS)) u_bank1 (
        .i_clk  (i_clk),
        .i_we   (we1),
        .i_waddr(r_row),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rd1)
    );

    l3d_row_acc #(.MAX_DIM(MAX_DIM)) u_acc (
        .i_clk      (i_clk),
        .i_ctl      (ctl),
        .i_row      (rdata),
        .i_xmask    (xmask),
        .i_moore    (r_moore),
        .i_row_live ((CW'(cy) < CW'(eff_y)) && (CW'(cz) < CW'(eff_z))),
        .i_under    (r_under),
        .i_over     (r_over),
        .i_birth    (r_birth),
        .i_sel_x    (r_px),
        .o_new_row  (new_row),
        .o_sel_alive(sel_alive),
        .o_sel_cnt  (sel_cnt)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_RST;
            r_size_y <= SIZE_RST;
            r_size_z <= SIZE_RST;
            r_moore  <= 1'b1;
            r_under  <= UNDER_RST;
            r_over   <= OVER_RST;
            r_birth  <= BIRTH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SIZE_X: r_size_x <= i_cfg_data;
                CFG_SIZE_Y: r_size_y <= i_cfg_data;
                CFG_SIZE_Z: r_size_z <= i_cfg_data;
                CFG_MOORE:  r_moore  <= i_cfg_data[0];
                CFG_UNDER:  r_under  <= i_cfg_data[CNT_W-1:0];
                CFG_OVER:   r_over   <= i_cfg_data[CNT_W-1:0];
                CFG_BIRTH:  r_birth  <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_row    <= '0;
            r_bank   <= 1'b0;
            r_gen    <= '0;
            r_strobe <= 1'b0;
            r_dctl   <= '0;
            r_dy     <= 2'd0;
            r_dz     <= 2'd0;
        end else begin
            r_strobe <= 1'b0;
            r_dctl   <= '0;
            unique case (r_state)
                S_CLEAR: begin
                    r_row <= r_row + AW'(1);
                    if (&r_row) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_req      <= i_req_type;
                        r_px       <= XW'(i_pos_x);
                        r_alive_in <= i_alive_in;
                        r_dy       <= 2'd0;
                        r_dz       <= 2'd0;
                        r_alive    <= 1'b0;
                        r_ncnt     <= '0;
                        r_oor      <= 1'b0;
                        priority if (i_req_type == REQ_ADV) begin
                            r_row   <= '0;
                            r_state <= S_GATHER;
                        end else if (i_req_type == REQ_NOP) begin
                            r_strobe <= 1'b1;
                        end else if (pos_oor) begin
                            r_oor    <= 1'b1;
                            r_strobe <= 1'b1;
                        end else begin
                            r_row   <= {XW'(i_pos_z), XW'(i_pos_y)};
                            r_state <= (i_req_type == REQ_WRITE) ? S_WREAD : S_GATHER;
                        end
                    end
                end
                S_WREAD: begin
                    r_state <= S_WMOD;
                end
                S_WMOD: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_GATHER: begin
                    r_dctl.add    <= 1'b1;
                    r_dctl.rowok  <= rowok;
                    r_dctl.center <= (r_dy == 2'd1) && (r_dz == 2'd1);
                    r_dctl.cls    <= 2'(r_dy != 2'd1) + 2'(r_dz != 2'd1);
                    if (r_dy == 2'd2) begin
                        r_dy <= 2'd0;
                        if (r_dz == 2'd2) begin
                            r_dz    <= 2'd0;
                            r_state <= S_DRAIN;
                        end else begin
                            r_dz <= r_dz + 2'd1;
                        end
                    end else begin
                        r_dy <= r_dy + 2'd1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (r_req == REQ_READ) begin
                        r_alive  <= sel_alive;
                        r_ncnt   <= sel_cnt;
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (&r_row) begin
                        r_gen    <= r_gen + GEN_W'(1);
                        r_bank   <= !r_bank;
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_row   <= r_row + AW'(1);
                        r_state <= S_GATHER;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result_valid    = r_strobe;
    assign o_alive_out       = r_alive;
    assign o_neighbour_count = r_ncnt;
    assign o_generation      = r_gen;
    assign o_out_of_range    = r_oor;

`ifndef SYNTHESIS
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    a_gen_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_gen != $past(r_gen))) |-> o_result_valid)
        else $error("generation changed without a result");

    a_nop_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req_type == REQ_NOP)) |=> o_result_valid)
        else $error("unused request gave no result");

    a_offsets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dy != 2'd3) && (r_dz != 2'd3))
        else $error("row offset counter overrun");
`endif

endmodule

>>> rtl/l3d_ram.sv
// ----------------------------------------------------------------------------
// l3d_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module l3d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/l3d_row_acc.sv
// ----------------------------------------------------------------------------
// l3d_row_acc
// Per-cell neighbour counters for one x-row. Each of the nine rows around
// it, its own row included, adds its contribution; the rule then gives the new row.
// ----------------------------------------------------------------------------
module l3d_row_acc
    import l3d_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                       i_clk,
    input  t_acc_ctl                   i_ctl,
    input  logic [MAX_DIM-1:0]         i_row,
    input  logic [MAX_DIM-1:0]         i_xmask,
    input  logic                       i_moore,
    input  logic                       i_row_live,
    input  logic [CNT_W-1:0]           i_under,
    input  logic [CNT_W-1:0]           i_over,
    input  logic [CNT_W-1:0]           i_birth,
    input  logic [$clog2(MAX_DIM)-1:0] i_sel_x,
    output logic [MAX_DIM-1:0]         o_new_row,
    output logic                       o_sel_alive,
    output logic [CNT_W-1:0]           o_sel_cnt
);

    logic [CNT_W-1:0]   r_cnt [MAX_DIM];
    logic [CNT_W-1:0]   n_cnt [MAX_DIM];
    logic [MAX_DIM-1:0] r_ctr;
    logic [MAX_DIM-1:0] row_m;

    always_comb begin
        logic       l, m, r;
        logic [1:0] s;
        row_m = i_ctl.rowok ? (i_row & i_xmask) : '0;
        for (int i = 0; i < MAX_DIM; i++) begin
            l = (i > 0) ? row_m[(i > 0) ? i - 1 : 0] : 1'b0;
            r = (i < MAX_DIM - 1) ? row_m[(i < MAX_DIM - 1) ? i + 1 : i] : 1'b0;
            m = row_m[i];
            unique case (i_ctl.cls)
                CLS_SELF: s = 2'(l) + 2'(r);
                CLS_FACE: s = 2'(m) + (i_moore ? 2'(l) + 2'(r) : 2'd0);
                CLS_EDGE: s = i_moore ? 2'(l) + 2'(m) + 2'(r) : 2'd0;
                default:  s = 2'd0;
            endcase
            if (i_ctl.clear) begin
                n_cnt[i] = '0;
            end else if (i_ctl.add) begin
                n_cnt[i] = r_cnt[i] + CNT_W'(s);
            end else begin
                n_cnt[i] = r_cnt[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_DIM; i++) begin
            r_cnt[i] <= n_cnt[i];
        end
        // The center row is kept unmasked so cells outside the extent survive.
        if (i_ctl.add && i_ctl.center) begin
            r_ctr <= i_row;
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_DIM; i++) begin
            if (i_row_live && i_xmask[i]) begin
                if (r_cnt[i] == '0) begin
                    o_new_row[i] = 1'b0;
                end else if (r_ctr[i]) begin
                    o_new_row[i] = (r_cnt[i] >= i_under) && (r_cnt[i] <= i_over);
                end else begin
                    o_new_row[i] = (r_cnt[i] == i_birth);
                end
            end else begin
                o_new_row[i] = r_ctr[i];
            end
        end
    end

    assign o_sel_alive = r_ctr[i_sel_x];
    assign o_sel_cnt   = r_cnt[i_sel_x];

endmodule
